@@ hw/rtl/sscp_pkg.sv @@
// Shared widths, stage numbering and pipeline record for the segment closest-points core.
package sscp_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DOT_W   = PROD_W + 2;
  localparam int HALF_W  = DOT_W / 2;
  localparam int PART_W  = 2 * HALF_W + 1;
  localparam int WIDE_W  = 2 * DOT_W + 2;
  localparam int PFRAC   = 16;
  localparam int PARAM_W = PFRAC + 1;
  localparam int LERP_W  = DIFF_W + PARAM_W + 1;
  localparam int LIMIT_W = 25;
  localparam int DIST_W  = 2 * COORD_W + 2;
  localparam int SUM_W   = PROD_W + 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16777);
  localparam logic [PARAM_W-1:0] PONE        = PARAM_W'(1) << PFRAC;
  localparam logic [PFRAC-1:0]   PHALF       = PFRAC'(1) << (PFRAC - 1);

  // Restoring divider: one check stage plus one stage per quotient bit
  localparam int DIV_LAT = PFRAC + 1;

  // Pipeline stage numbers (register index that holds each result)
  localparam int ST_DIFF = 1;
  localparam int ST_PROD = 2;
  localparam int ST_DOT  = 3;
  localparam int ST_PART = 4;
  localparam int ST_WIDE = 5;
  localparam int ST_DEN  = 6;
  localparam int ST_SQ   = ST_DEN + DIV_LAT + 1;
  localparam int ST_BS   = ST_SQ + 1;
  localparam int ST_TNUM = ST_BS + 1;
  localparam int ST_SEL  = ST_TNUM + DIV_LAT + 1;
  localparam int ST_LERP = ST_SEL + 1;
  localparam int ST_NEAR = ST_LERP + 1;
  localparam int ST_SQR  = ST_NEAR + 1;
  localparam int ST_LAST = ST_SQR + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic [PARAM_W-1:0]        param_t;
  typedef logic [LIMIT_W-1:0]        limit_t;
  typedef logic [DIST_W-1:0]         dist_t;

  // Everything one beat carries down the pipeline
  typedef struct packed {
    coord_t [2:0]              p1;
    coord_t [2:0]              p2;
    diff_t  [2:0]              d1;
    diff_t  [2:0]              d2;
    diff_t  [2:0]              r;
    logic   [14:0][PROD_W-1:0] prod;
    dot_t                      a;
    dot_t                      e;
    dot_t                      b;
    dot_t                      c;
    dot_t                      f;
    logic                      adeg;
    logic                      edeg;
    logic   [15:0][PART_W-1:0] part;
    wide_t                     ae;
    wide_t                     bb;
    wide_t                     bf;
    wide_t                     ce;
    wide_t                     den;
    wide_t                     snum;
    param_t                    s_gen;
    param_t                    sa0;
    param_t                    sa1;
    param_t                    tdeg;
    wide_t                     bs;
    wide_t                     tnum;
    wide_t                     tden;
    logic                      tneg;
    logic                      tgt;
    param_t                    s;
    param_t                    t;
    logic   [2:0][LERP_W-1:0]  ds;
    logic   [2:0][LERP_W-1:0]  dt;
    coord_t [2:0]              c1;
    coord_t [2:0]              c2;
    logic   [2:0][PROD_W-1:0]  sq;
    dist_t                     dsq;
  } pipe_t;

endpackage

@@ hw/rtl/sscp_div.sv @@
// Pipelined clamped fraction divider: q = clamp(floor(num * 2^16 / den), 0, 1.0).
module sscp_div (
  input  logic            clk_i,
  input  sscp_pkg::wide_t num_i,
  input  sscp_pkg::wide_t den_i,
  output sscp_pkg::param_t q_o
);
  import sscp_pkg::*;

  logic [WIDE_W-1:0] rem_q  [DIV_LAT];
  logic [WIDE_W-1:0] rem_d  [DIV_LAT];
  logic [WIDE_W-1:0] den_q  [DIV_LAT];
  logic [WIDE_W-1:0] den_d  [DIV_LAT];
  logic [PFRAC-1:0]  quo_q  [DIV_LAT];
  logic [PFRAC-1:0]  quo_d  [DIV_LAT];
  logic              zero_q [DIV_LAT];
  logic              zero_d [DIV_LAT];
  logic              one_q  [DIV_LAT];
  logic              one_d  [DIV_LAT];

  // Check stage, then one quotient bit per stage
  always_comb begin
    logic [WIDE_W-1:0] sh;
    sh        = '0;
    rem_d[0]  = num_i;
    den_d[0]  = den_i;
    quo_d[0]  = '0;
    zero_d[0] = (num_i <= 0);
    one_d[0]  = (num_i >= den_i);
    for (int j = 1; j < DIV_LAT; j++) begin
      sh        = {rem_q[j-1][WIDE_W-2:0], 1'b0};
      den_d[j]  = den_q[j-1];
      zero_d[j] = zero_q[j-1];
      one_d[j]  = one_q[j-1];
      if (sh >= den_q[j-1]) begin
        rem_d[j] = sh - den_q[j-1];
        quo_d[j] = {quo_q[j-1][PFRAC-2:0], 1'b1};
      end else begin
        rem_d[j] = sh;
        quo_d[j] = {quo_q[j-1][PFRAC-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
    zero_q <= zero_d;
    one_q  <= one_d;
  end

  // Clamp to the ends of the range
  assign q_o = zero_q[DIV_LAT-1] ? '0 :
               one_q[DIV_LAT-1]  ? PONE : {1'b0, quo_q[DIV_LAT-1]};

endmodule

@@ hw/rtl/segment_segment_closest_points_core.sv @@
// Top level: pipelined closest points between two 3D segments.
//
// Use: drive the twelve Q12.12 endpoint coordinates and raise start_i for
// one cycle per segment pair. busy_o is always low, so a pair is taken at
// every edge where start_i is high: one beat per clock, sustained.
// Each beat gives one result: done_o is high for exactly one cycle with s, t
// (Q1.16), both closest points and the squared distance.
// Results leave in the order the pairs came in. The latency is set by two
// 17-stage restoring dividers in series (s first, then t from the quantised
// s) plus the dot-product, wide-product and interpolation stages around them.
// The receiver cannot stall; results are not held.
// degenerate_limit is written by cfg_we_i / cfg_wdata_i; the user must write it
// only while no beat is in flight, as the core does not enforce this. Reset (rst_ni low, asynchronous) clears
// every valid bit and loads the limit with its default of 16777; beats in flight are dropped.
module segment_segment_closest_points_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              cfg_we_i,
  input  sscp_pkg::limit_t  cfg_wdata_i,
  input  sscp_pkg::coord_t  seg1_start_x_i,
  input  sscp_pkg::coord_t  seg1_start_y_i,
  input  sscp_pkg::coord_t  seg1_start_z_i,
  input  sscp_pkg::coord_t  seg1_end_x_i,
  input  sscp_pkg::coord_t  seg1_end_y_i,
  input  sscp_pkg::coord_t  seg1_end_z_i,
  input  sscp_pkg::coord_t  seg2_start_x_i,
  input  sscp_pkg::coord_t  seg2_start_y_i,
  input  sscp_pkg::coord_t  seg2_start_z_i,
  input  sscp_pkg::coord_t  seg2_end_x_i,
  input  sscp_pkg::coord_t  seg2_end_y_i,
  input  sscp_pkg::coord_t  seg2_end_z_i,
  output logic              done_o,
  output sscp_pkg::dist_t   dist_squared_o,
  output sscp_pkg::param_t  param_first_o,
  output sscp_pkg::param_t  param_second_o,
  output sscp_pkg::coord_t  near1_x_o,
  output sscp_pkg::coord_t  near1_y_o,
  output sscp_pkg::coord_t  near1_z_o,
  output sscp_pkg::coord_t  near2_x_o,
  output sscp_pkg::coord_t  near2_y_o,
  output sscp_pkg::coord_t  near2_z_o
);
  import sscp_pkg::*;

  pipe_t            pipe_q [1:ST_LAST];
  pipe_t            pipe_d [1:ST_LAST];
  logic [ST_LAST:1] v_q;
  logic [ST_LAST:1] v_d;
  limit_t           limit_q;
  param_t           q_main;
  param_t           q_alt0;
  param_t           q_alt1;
  param_t           q_tdeg;
  param_t           q_t;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Valid bits travel with the beats
  assign v_d = {v_q[ST_LAST-1:1], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Stage datapath
  always_comb begin
    coord_t            p1 [3];
    coord_t            q1 [3];
    coord_t            p2 [3];
    coord_t            q2 [3];
    dot_t              xs [4];
    dot_t              ys [4];
    logic signed [HALF_W-1:0] xh;
    logic signed [HALF_W-1:0] yh;
    logic signed [HALF_W:0]   xl;
    logic signed [HALF_W:0]   yl;
    wide_t             wp [4];
    logic signed [LERP_W:0]   v1;
    logic signed [LERP_W:0]   v2;
    diff_t             dd;
    logic [SUM_W-1:0]  sum;

    p1 = '{seg1_start_x_i, seg1_start_y_i, seg1_start_z_i};
    q1 = '{seg1_end_x_i, seg1_end_y_i, seg1_end_z_i};
    p2 = '{seg2_start_x_i, seg2_start_y_i, seg2_start_z_i};
    q2 = '{seg2_end_x_i, seg2_end_y_i, seg2_end_z_i};

    pipe_d[1] = pipe_q[1];
    for (int k = 2; k <= ST_LAST; k++) begin
      pipe_d[k] = pipe_q[k-1];
    end

    // Stage 1: segment directions and start offset
    for (int i = 0; i < 3; i++) begin
      pipe_d[ST_DIFF].p1[i] = p1[i];
      pipe_d[ST_DIFF].p2[i] = p2[i];
      pipe_d[ST_DIFF].d1[i] = DIFF_W'(q1[i]) - DIFF_W'(p1[i]);
      pipe_d[ST_DIFF].d2[i] = DIFF_W'(q2[i]) - DIFF_W'(p2[i]);
      pipe_d[ST_DIFF].r[i]  = DIFF_W'(p1[i]) - DIFF_W'(p2[i]);
    end

    // Stage 2: the fifteen component products
    for (int i = 0; i < 3; i++) begin
      pipe_d[ST_PROD].prod[i] =
        PROD_W'($signed(pipe_q[ST_PROD-1].d1[i])) * PROD_W'($signed(pipe_q[ST_PROD-1].d1[i]));
      pipe_d[ST_PROD].prod[3+i] =
        PROD_W'($signed(pipe_q[ST_PROD-1].d2[i])) * PROD_W'($signed(pipe_q[ST_PROD-1].d2[i]));
      pipe_d[ST_PROD].prod[6+i] =
        PROD_W'($signed(pipe_q[ST_PROD-1].d1[i])) * PROD_W'($signed(pipe_q[ST_PROD-1].d2[i]));
      pipe_d[ST_PROD].prod[9+i] =
        PROD_W'($signed(pipe_q[ST_PROD-1].d1[i])) * PROD_W'($signed(pipe_q[ST_PROD-1].r[i]));
      pipe_d[ST_PROD].prod[12+i] =
        PROD_W'($signed(pipe_q[ST_PROD-1].d2[i])) * PROD_W'($signed(pipe_q[ST_PROD-1].r[i]));
    end

    // Stage 3: dot products and degenerate flags
    pipe_d[ST_DOT].a = DOT_W'($signed(pipe_q[ST_DOT-1].prod[0]))
                     + DOT_W'($signed(pipe_q[ST_DOT-1].prod[1]))
                     + DOT_W'($signed(pipe_q[ST_DOT-1].prod[2]));
    pipe_d[ST_DOT].e = DOT_W'($signed(pipe_q[ST_DOT-1].prod[3]))
                     + DOT_W'($signed(pipe_q[ST_DOT-1].prod[4]))
                     + DOT_W'($signed(pipe_q[ST_DOT-1].prod[5]));
    pipe_d[ST_DOT].b = DOT_W'($signed(pipe_q[ST_DOT-1].prod[6]))
                     + DOT_W'($signed(pipe_q[ST_DOT-1].prod[7]))
                     + DOT_W'($signed(pipe_q[ST_DOT-1].prod[8]));
    pipe_d[ST_DOT].c = DOT_W'($signed(pipe_q[ST_DOT-1].prod[9]))
                     + DOT_W'($signed(pipe_q[ST_DOT-1].prod[10]))
                     + DOT_W'($signed(pipe_q[ST_DOT-1].prod[11]));
    pipe_d[ST_DOT].f = DOT_W'($signed(pipe_q[ST_DOT-1].prod[12]))
                     + DOT_W'($signed(pipe_q[ST_DOT-1].prod[13]))
                     + DOT_W'($signed(pipe_q[ST_DOT-1].prod[14]));
    pipe_d[ST_DOT].adeg = ($unsigned(pipe_d[ST_DOT].a) <= DOT_W'(limit_q));
    pipe_d[ST_DOT].edeg = ($unsigned(pipe_d[ST_DOT].e) <= DOT_W'(limit_q));

    // Stage 4: half-width partial products of a*e, b*b, b*f, c*e
    xs = '{pipe_q[ST_PART-1].a, pipe_q[ST_PART-1].b, pipe_q[ST_PART-1].b, pipe_q[ST_PART-1].c};
    ys = '{pipe_q[ST_PART-1].e, pipe_q[ST_PART-1].b, pipe_q[ST_PART-1].f, pipe_q[ST_PART-1].e};
    for (int j = 0; j < 4; j++) begin
      xh = xs[j][DOT_W-1:HALF_W];
      yh = ys[j][DOT_W-1:HALF_W];
      xl = {1'b0, xs[j][HALF_W-1:0]};
      yl = {1'b0, ys[j][HALF_W-1:0]};
      pipe_d[ST_PART].part[4*j]   = PART_W'(xh) * PART_W'(yh);
      pipe_d[ST_PART].part[4*j+1] = PART_W'(xh) * PART_W'(yl);
      pipe_d[ST_PART].part[4*j+2] = PART_W'(xl) * PART_W'(yh);
      pipe_d[ST_PART].part[4*j+3] = PART_W'(xl) * PART_W'(yl);
    end

    // Stage 5: recombine the partials
    for (int j = 0; j < 4; j++) begin
      wp[j] = (WIDE_W'($signed(pipe_q[ST_WIDE-1].part[4*j])) <<< (2 * HALF_W))
            + ((WIDE_W'($signed(pipe_q[ST_WIDE-1].part[4*j+1]))
              + WIDE_W'($signed(pipe_q[ST_WIDE-1].part[4*j+2]))) <<< HALF_W)
            + WIDE_W'($signed(pipe_q[ST_WIDE-1].part[4*j+3]));
    end
    pipe_d[ST_WIDE].ae = wp[0];
    pipe_d[ST_WIDE].bb = wp[1];
    pipe_d[ST_WIDE].bf = wp[2];
    pipe_d[ST_WIDE].ce = wp[3];

    // Stage 6: denominator and s numerator
    pipe_d[ST_DEN].den  = pipe_q[ST_DEN-1].ae - pipe_q[ST_DEN-1].bb;
    pipe_d[ST_DEN].snum = pipe_q[ST_DEN-1].bf - pipe_q[ST_DEN-1].ce;

    // Quotients out of the first divider bank; parallel segments take s = 0
    pipe_d[ST_SQ].s_gen = (pipe_q[ST_SQ-1].den == '0) ? '0 : q_main;
    pipe_d[ST_SQ].sa0   = q_alt0;
    pipe_d[ST_SQ].sa1   = q_alt1;
    pipe_d[ST_SQ].tdeg  = q_tdeg;

    // b * s with the quantised s
    pipe_d[ST_BS].bs = WIDE_W'(pipe_q[ST_BS-1].b)
                     * WIDE_W'($signed({1'b0, pipe_q[ST_BS-1].s_gen}));

    // t numerator and range checks
    pipe_d[ST_TNUM].tnum = pipe_q[ST_TNUM-1].bs + (WIDE_W'(pipe_q[ST_TNUM-1].f) <<< PFRAC);
    pipe_d[ST_TNUM].tden = WIDE_W'(pipe_q[ST_TNUM-1].e) <<< PFRAC;
    pipe_d[ST_TNUM].tneg = pipe_d[ST_TNUM].tnum < 0;
    pipe_d[ST_TNUM].tgt  = pipe_d[ST_TNUM].tnum > pipe_d[ST_TNUM].tden;

    // Pick s and t by case
    if (pipe_q[ST_SEL-1].adeg && pipe_q[ST_SEL-1].edeg) begin
      pipe_d[ST_SEL].s = '0;
      pipe_d[ST_SEL].t = '0;
    end else if (pipe_q[ST_SEL-1].adeg) begin
      pipe_d[ST_SEL].s = '0;
      pipe_d[ST_SEL].t = pipe_q[ST_SEL-1].tdeg;
    end else if (pipe_q[ST_SEL-1].edeg || pipe_q[ST_SEL-1].tneg) begin
      pipe_d[ST_SEL].s = pipe_q[ST_SEL-1].sa0;
      pipe_d[ST_SEL].t = '0;
    end else if (pipe_q[ST_SEL-1].tgt) begin
      pipe_d[ST_SEL].s = pipe_q[ST_SEL-1].sa1;
      pipe_d[ST_SEL].t = PONE;
    end else begin
      pipe_d[ST_SEL].s = pipe_q[ST_SEL-1].s_gen;
      pipe_d[ST_SEL].t = q_t;
    end

    // Direction times parameter
    for (int i = 0; i < 3; i++) begin
      pipe_d[ST_LERP].ds[i] = LERP_W'($signed(pipe_q[ST_LERP-1].d1[i]))
                            * LERP_W'($signed({1'b0, pipe_q[ST_LERP-1].s}));
      pipe_d[ST_LERP].dt[i] = LERP_W'($signed(pipe_q[ST_LERP-1].d2[i]))
                            * LERP_W'($signed({1'b0, pipe_q[ST_LERP-1].t}));
    end

    // Round half up and add to the start point
    for (int i = 0; i < 3; i++) begin
      v1 = ((LERP_W+1)'($signed(pipe_q[ST_NEAR-1].ds[i]))
           + (LERP_W+1)'($signed({1'b0, PHALF}))) >>> PFRAC;
      v2 = ((LERP_W+1)'($signed(pipe_q[ST_NEAR-1].dt[i]))
           + (LERP_W+1)'($signed({1'b0, PHALF}))) >>> PFRAC;
      pipe_d[ST_NEAR].c1[i] = pipe_q[ST_NEAR-1].p1[i] + v1[COORD_W-1:0];
      pipe_d[ST_NEAR].c2[i] = pipe_q[ST_NEAR-1].p2[i] + v2[COORD_W-1:0];
    end

    // Squared component gaps
    for (int i = 0; i < 3; i++) begin
      dd = DIFF_W'($signed(pipe_q[ST_SQR-1].c1[i])) - DIFF_W'($signed(pipe_q[ST_SQR-1].c2[i]));
      pipe_d[ST_SQR].sq[i] = PROD_W'(dd) * PROD_W'(dd);
    end

    // Sum and saturate
    sum = SUM_W'(pipe_q[ST_LAST-1].sq[0]) + SUM_W'(pipe_q[ST_LAST-1].sq[1])
        + SUM_W'(pipe_q[ST_LAST-1].sq[2]);
    pipe_d[ST_LAST].dsq = (sum[SUM_W-1:DIST_W] != '0) ? '1 : sum[DIST_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  // Divider banks
  sscp_div u_div_main (
    .clk_i (clk_i),
    .num_i (pipe_q[ST_DEN].snum),
    .den_i (pipe_q[ST_DEN].den),
    .q_o   (q_main)
  );

  sscp_div u_div_alt0 (
    .clk_i (clk_i),
    .num_i (-WIDE_W'(pipe_q[ST_DEN].c)),
    .den_i (WIDE_W'(pipe_q[ST_DEN].a)),
    .q_o   (q_alt0)
  );

  sscp_div u_div_alt1 (
    .clk_i (clk_i),
    .num_i (WIDE_W'(pipe_q[ST_DEN].b) - WIDE_W'(pipe_q[ST_DEN].c)),
    .den_i (WIDE_W'(pipe_q[ST_DEN].a)),
    .q_o   (q_alt1)
  );

  sscp_div u_div_tdeg (
    .clk_i (clk_i),
    .num_i (WIDE_W'(pipe_q[ST_DEN].f)),
    .den_i (WIDE_W'(pipe_q[ST_DEN].e)),
    .q_o   (q_tdeg)
  );

  sscp_div u_div_t (
    .clk_i (clk_i),
    .num_i (pipe_q[ST_TNUM].tnum),
    .den_i (pipe_q[ST_TNUM].tden),
    .q_o   (q_t)
  );

  // Outputs
  assign busy_o         = 1'b0;
  assign done_o         = v_q[ST_LAST];
  assign dist_squared_o = pipe_q[ST_LAST].dsq;
  assign param_first_o  = pipe_q[ST_LAST].s;
  assign param_second_o = pipe_q[ST_LAST].t;
  assign near1_x_o      = pipe_q[ST_LAST].c1[0];
  assign near1_y_o      = pipe_q[ST_LAST].c1[1];
  assign near1_z_o      = pipe_q[ST_LAST].c1[2];
  assign near2_x_o      = pipe_q[ST_LAST].c2[0];
  assign near2_y_o      = pipe_q[ST_LAST].c2[1];
  assign near2_z_o      = pipe_q[ST_LAST].c2[2];

  // Checks
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##ST_LAST done_o)
    else $error("result strobe missing after fixed latency");

  a_param_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (param_first_o <= PONE) && (param_second_o <= PONE))
    else $error("parameter out of range");

  a_deg_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_SEL] && pipe_q[ST_SEL].adeg |-> pipe_q[ST_SEL].s == '0)
    else $error("degenerate first segment with non-zero s");

  a_deg_both : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_LERP] && pipe_q[ST_LERP].adeg && pipe_q[ST_LERP].edeg |=>
      pipe_q[ST_NEAR].c1 == pipe_q[ST_NEAR].p1)
    else $error("degenerate pair moved the first point");

endmodule

@@ verif/tb_segment_segment_closest_points_core.sv @@
// Testbench for the segment closest-points core: directed table, random pairs, own predictor.
`timescale 1ns / 1ps

module tb_segment_segment_closest_points_core;
  import sscp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM    = 1000;
  localparam int DRAIN_WAIT  = 60;

  typedef logic signed [127:0] acc_t;

  typedef struct packed {
    coord_t [2:0] p1;
    coord_t [2:0] q1;
    coord_t [2:0] p2;
    coord_t [2:0] q2;
  } seg_pair_t;

  typedef struct packed {
    dist_t        dsq;
    param_t       s;
    param_t       t;
    coord_t [2:0] c1;
    coord_t [2:0] c2;
  } closest_t;

  typedef struct {
    seg_pair_t pair;
    bit        typed;
    closest_t  res;
  } table_row_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start_i = 1'b0;
  logic   busy_o;
  logic   cfg_we_i = 1'b0;
  limit_t cfg_wdata_i = '0;
  seg_pair_t drv = '0;
  logic   done_o;
  dist_t  dist_squared_o;
  param_t param_first_o, param_second_o;
  coord_t near1_x_o, near1_y_o, near1_z_o, near2_x_o, near2_y_o, near2_z_o;

  closest_t   pending_closest[$];
  limit_t     limit_copy = LIMIT_RESET;
  bit         drv_typed = 1'b0;
  closest_t   drv_res = '0;
  int         beats_taken = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         cycles = 0;
  table_row_t dir_rows[$];

  always #5 clk_i = ~clk_i;

  segment_segment_closest_points_core i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_wdata_i,
    .seg1_start_x_i(drv.p1[0]), .seg1_start_y_i(drv.p1[1]), .seg1_start_z_i(drv.p1[2]),
    .seg1_end_x_i  (drv.q1[0]), .seg1_end_y_i  (drv.q1[1]), .seg1_end_z_i  (drv.q1[2]),
    .seg2_start_x_i(drv.p2[0]), .seg2_start_y_i(drv.p2[1]), .seg2_start_z_i(drv.p2[2]),
    .seg2_end_x_i  (drv.q2[0]), .seg2_end_y_i  (drv.q2[1]), .seg2_end_z_i  (drv.q2[2]),
    .done_o, .dist_squared_o, .param_first_o, .param_second_o,
    .near1_x_o, .near1_y_o, .near1_z_o, .near2_x_o, .near2_y_o, .near2_z_o
  );

  // clamp(floor(num * 2^16 / den), 0, 1) with den > 0
  function automatic param_t ratio_q16(acc_t num, acc_t den);
    if (num <= 0) return '0;
    if (num >= den) return PONE;
    return param_t'((num <<< PFRAC) / den);
  endfunction

  function automatic acc_t lerp_q16(coord_t p, acc_t d, param_t s);
    acc_t v;
    v = d * acc_t'(s) + acc_t'(PHALF);
    return acc_t'(p) + (v >>> PFRAC);
  endfunction

  function automatic closest_t predict_closest(seg_pair_t sp, limit_t lim);
    acc_t     d1[3], d2[3], r[3];
    acc_t     a, e, b, c, f, den, tnum, tden, dd, sum, k1, k2;
    param_t   s, t;
    closest_t res;
    a = 0; e = 0; b = 0; c = 0; f = 0; sum = 0;
    for (int i = 0; i < 3; i++) begin
      d1[i] = acc_t'(sp.q1[i]) - acc_t'(sp.p1[i]);
      d2[i] = acc_t'(sp.q2[i]) - acc_t'(sp.p2[i]);
      r[i]  = acc_t'(sp.p1[i]) - acc_t'(sp.p2[i]);
      a += d1[i] * d1[i];
      e += d2[i] * d2[i];
      b += d1[i] * d2[i];
      c += d1[i] * r[i];
      f += d2[i] * r[i];
    end
    s = '0;
    t = '0;
    if (a <= acc_t'(lim) && e <= acc_t'(lim)) begin
      // both collapse to points
    end else if (a <= acc_t'(lim)) begin
      t = ratio_q16(f, e);
    end else if (e <= acc_t'(lim)) begin
      s = ratio_q16(-c, a);
    end else begin
      den = a * e - b * b;
      s = (den == 0) ? param_t'(0) : ratio_q16(b * f - c * e, den);
      tnum = b * acc_t'(s) + (f <<< PFRAC);
      tden = e <<< PFRAC;
      if (tnum < 0) begin
        t = '0;
        s = ratio_q16(-c, a);
      end else if (tnum > tden) begin
        t = PONE;
        s = ratio_q16(b - c, a);
      end else begin
        t = ratio_q16(tnum, tden);
      end
    end
    for (int i = 0; i < 3; i++) begin
      k1 = lerp_q16(sp.p1[i], d1[i], s);
      k2 = lerp_q16(sp.p2[i], d2[i], t);
      res.c1[i] = coord_t'(k1);
      res.c2[i] = coord_t'(k2);
      dd = k1 - k2;
      sum += dd * dd;
    end
    if (sum > acc_t'({DIST_W{1'b1}})) sum = acc_t'({DIST_W{1'b1}});
    res.dsq = dist_t'(sum);
    res.s = s;
    res.t = t;
    return res;
  endfunction

  function automatic seg_pair_t mk_pair(int ax, ay, az, bx, by, bz, cx, cy, cz, ex, ey, ez);
    seg_pair_t sp;
    sp.p1 = {coord_t'(az), coord_t'(ay), coord_t'(ax)};
    sp.q1 = {coord_t'(bz), coord_t'(by), coord_t'(bx)};
    sp.p2 = {coord_t'(cz), coord_t'(cy), coord_t'(cx)};
    sp.q2 = {coord_t'(ez), coord_t'(ey), coord_t'(ex)};
    return sp;
  endfunction

  function automatic coord_t near_coord(int span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Random pair, weighted toward the interesting shapes
  function automatic seg_pair_t rand_pair();
    seg_pair_t sp;
    int        kind, k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      sp.p1[i] = coord_t'($urandom);
      sp.q1[i] = coord_t'($urandom);
      sp.p2[i] = coord_t'($urandom);
      sp.q2[i] = coord_t'($urandom);
    end
    k = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      case (kind)
        3, 4: begin
          sp.p1[i] = near_coord(16384); sp.q1[i] = near_coord(16384);
          sp.p2[i] = near_coord(16384); sp.q2[i] = near_coord(16384);
        end
        5: sp.q1[i] = coord_t'(int'(near_coord(1 << 20)) + int'(near_coord(64)));
        6: sp.q2[i] = coord_t'(int'(near_coord(1 << 20)) + int'(near_coord(64)));
        7: begin
          sp.p1[i] = near_coord(1 << 21);
          sp.q1[i] = coord_t'(int'(sp.p1[i]) + int'(near_coord(1 << 19)));
          sp.p2[i] = near_coord(1 << 21);
          sp.q2[i] = coord_t'(int'(sp.p2[i]) +
                     (k == 0 ? 1 : (k == 1 ? -1 : 2)) * (int'(sp.q1[i]) - int'(sp.p1[i])));
        end
        8: begin
          sp.q1[i] = coord_t'(int'(sp.p1[i]) + int'(near_coord(32)));
          sp.q2[i] = coord_t'(int'(sp.p2[i]) + int'(near_coord(32)));
        end
        9: sp.p2[i] = sp.q1[i];
        default: ;
      endcase
    end
    if (kind == 5) sp.p1 = sp.q1;
    if (kind == 6) sp.p2 = sp.q2;
    return sp;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic check_field(string what, longint unsigned got, longint unsigned want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Sample beats, results and register writes at the rising edge
  always @(posedge clk_i) begin
    closest_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_closest.size());
      $display("== FAIL ==");
      $finish;
    end else if (rst_ni) begin
      if (done_o === 1'b1) begin
        results_seen++;
        if (pending_closest.size() == 0) begin
          report_mismatch("unexpected result", dist_squared_o, 0);
        end else begin
          want = pending_closest.pop_front();
          check_field("dist_squared", dist_squared_o, want.dsq);
          check_field("param_first", param_first_o, want.s);
          check_field("param_second", param_second_o, want.t);
          check_field("near1_x", {40'd0, near1_x_o}, {40'd0, want.c1[0]});
          check_field("near1_y", {40'd0, near1_y_o}, {40'd0, want.c1[1]});
          check_field("near1_z", {40'd0, near1_z_o}, {40'd0, want.c1[2]});
          check_field("near2_x", {40'd0, near2_x_o}, {40'd0, want.c2[0]});
          check_field("near2_y", {40'd0, near2_y_o}, {40'd0, want.c2[1]});
          check_field("near2_z", {40'd0, near2_z_o}, {40'd0, want.c2[2]});
        end
      end
      if (start_i && !busy_o) begin
        pending_closest.push_back(drv_typed ? drv_res : predict_closest(drv, limit_copy));
        beats_taken++;
      end
      if (cfg_we_i) limit_copy = cfg_wdata_i;
    end
  end

  // One beat: hold start until the core takes it, optional gap before
  task automatic send_pair(seg_pair_t sp, bit typed, closest_t res, bit quiet);
    int n;
    if (!quiet && $urandom_range(0, 99) < 5) begin
      start_i <= 1'b0;
      drv     <= rand_pair();
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    drv       <= sp;
    drv_typed = typed;
    drv_res   = res;
    start_i   <= 1'b1;
    n = beats_taken;
    do @(negedge clk_i); while (beats_taken == n);
  endtask

  task automatic write_limit(limit_t value);
    start_i <= 1'b0;
    wait (pending_closest.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    table_row_t row;
    limit_t     phase_limits[6];
    closest_t   none;
    none = '0;
    phase_limits = '{limit_t'(0), limit_t'(16777216), limit_t'(1),
                     limit_t'(1 << 20), limit_t'(0), LIMIT_RESET};

    // Directed rows: typed results only where obvious
    row.typed = 1'b1; row.res = '0;
    row.pair = mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_rows.push_back(row);
    row.pair = mk_pair(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                       -8388608, -8388608, -8388608, -8388608, -8388608, -8388608);
    row.res.dsq = dist_t'(50'd844424829468675);
    row.res.c1 = {coord_t'(8388607), coord_t'(8388607), coord_t'(8388607)};
    row.res.c2 = {coord_t'(-8388608), coord_t'(-8388608), coord_t'(-8388608)};
    dir_rows.push_back(row);
    row.pair = mk_pair(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                       8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
    row.res.c1 = {coord_t'(-8388608), coord_t'(-8388608), coord_t'(-8388608)};
    row.res.c2 = {coord_t'(8388607), coord_t'(8388607), coord_t'(8388607)};
    dir_rows.push_back(row);
    row.typed = 1'b0; row.res = '0;
    // full-range diagonals crossing
    row.pair = mk_pair(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                       8388607, -8388608, 8388607, -8388608, 8388607, -8388608);
    dir_rows.push_back(row);
    // parallel, overlapping; then reversed; then disjoint beyond the end
    row.pair = mk_pair(0, 0, 0, 16384, 0, 0, 4096, 4096, 0, 20480, 4096, 0);
    dir_rows.push_back(row);
    row.pair = mk_pair(0, 0, 0, 16384, 0, 0, 20480, 4096, 0, 4096, 4096, 0);
    dir_rows.push_back(row);
    row.pair = mk_pair(0, 0, 0, 16384, 0, 0, -40960, 4096, 0, -20480, 4096, 0);
    dir_rows.push_back(row);
    // first segment a point, then second segment a point
    row.pair = mk_pair(4096, 8192, 0, 4096, 8192, 1, 0, 0, 0, 16384, 0, 0);
    dir_rows.push_back(row);
    row.pair = mk_pair(0, 0, 0, 16384, 0, 0, 4096, 8192, 0, 4096, 8192, 1);
    dir_rows.push_back(row);
    // perpendicular skew lines
    row.pair = mk_pair(-8192, 0, 0, 8192, 0, 0, 0, -8192, 4096, 0, 8192, 4096);
    dir_rows.push_back(row);
    // t clamped below zero, then above one
    row.pair = mk_pair(0, 0, 0, 8192, 0, 0, 4096, 8192, 0, 4096, 40960, 4096);
    dir_rows.push_back(row);
    row.pair = mk_pair(0, 0, 0, 8192, 0, 0, 4096, -40960, 0, 4096, -8192, 4096);
    dir_rows.push_back(row);
    // the same segment twice, and a shared endpoint
    row.pair = mk_pair(100, -200, 300, 50000, 60000, -70000, 100, -200, 300,
                       50000, 60000, -70000);
    dir_rows.push_back(row);
    row.pair = mk_pair(0, 0, 0, 16384, 16384, 0, 16384, 16384, 0, 32768, 0, 0);
    dir_rows.push_back(row);
    // both just below the default degenerate limit, then the second just above it
    row.pair = mk_pair(0, 0, 0, 128, 0, 0, 1000, 1000, 0, 1000, 1129, 0);
    dir_rows.push_back(row);
    row.pair = mk_pair(0, 0, 0, 129, 0, 0, 1000, 1000, 0, 1000, 1130, 0);
    dir_rows.push_back(row);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_pair(dir_rows[i].pair, dir_rows[i].typed, dir_rows[i].res, 1'b0);

    // Random part across the limit settings, one quiet stretch in the middle
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(ph == 4 ? limit_t'($urandom_range(0, 16777216)) : phase_limits[ph]);
      for (int i = 0; i < N_RANDOM / 6; i++)
        send_pair(rand_pair(), 1'b0, none, ph == 2);
    end
    start_i <= 1'b0;

    wait (pending_closest.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    $display("%0d beats sent (%0d from the table), %0d results checked over 7 limit settings",
             beats_taken, dir_rows.size(), results_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && pending_closest.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
